FILE: rtl/instance_distribution_selector_core_macros.svh
// Assertion shorthands shared by the selector modules.
`ifndef INSTANCE_DISTRIBUTION_SELECTOR_CORE_MACROS_SVH
`define INSTANCE_DISTRIBUTION_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define IDS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define IDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ids_pkg.sv
package ids_pkg;

    localparam int MAX_INSTANCES_DEF = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 5;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 1'b1;

    localparam logic [1:0] MODE_RR    = 2'd0;
    localparam logic [1:0] MODE_LEAST = 2'd1;
    localparam logic [1:0] MODE_RANGE = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_NO_INST  = 3'd1;
    localparam logic [2:0] STATUS_BAD_CHAR = 3'd2;
    localparam logic [2:0] STATUS_REFUSED  = 3'd3;
    localparam logic [2:0] STATUS_NO_ALG   = 3'd4;

    // Letters per instance, ceil(26 / count), indexed by the instance count.
    localparam logic [DIVISOR_W-1:0] PER_TABLE [32] = '{
        5'd1,  5'd26, 5'd13, 5'd9,  5'd7,  5'd6,  5'd5,  5'd4,
        5'd4,  5'd3,  5'd3,  5'd3,  5'd3,  5'd2,  5'd2,  5'd2,
        5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,
        5'd2,  5'd2,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1
    };

    typedef struct packed {
        logic       capture;
        logic       cap_load;
        logic       rr_step;
        logic       div_start;
        logic       range_sel;
        logic       scan_clear;
        logic       scan_step;
        logic       sel_load;
        logic       rd_sel;
        logic       upd_write;
        logic       res_set;
        logic [2:0] res_status;
        logic       res_stored;
        logic       out_load;
    } ids_cmd_t;

    typedef struct packed {
        logic       opcode;
        logic       tgt_in_range;
        logic       n_zero;
        logic [1:0] mode;
        logic       char_ok;
        logic       store_ok;
        logic       div_done;
        logic       scan_last;
        logic       out_free;
    } ids_stat_t;

endpackage

FILE: rtl/ids_div.sv
module ids_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ids_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [ids_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [ids_pkg::DIVIDEND_W-1:0]   quotient,
    output logic [ids_pkg::DIVISOR_W-1:0]    remainder
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [ids_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [ids_pkg::DIVIDEND_W-1:0]    dvd_reg;
    logic [ids_pkg::DIVISOR_W-1:0]     dvs_reg;
    logic [ids_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [ids_pkg::DIVISOR_W:0]       trial;
    logic [ids_pkg::DIVISOR_W:0]       diff;
    logic                              ge;
    logic [ids_pkg::DIVISOR_W-1:0]     rem_next;

    // One quotient bit per cycle; the quotient shifts in behind the dividend.
    assign trial    = {rem_reg, dvd_reg[ids_pkg::DIVIDEND_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[ids_pkg::DIVISOR_W-1:0] : trial[ids_pkg::DIVISOR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + ids_pkg::DIV_CNT_W'(1);
                if (cnt_reg == ids_pkg::DIV_CNT_W'(ids_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ids_pkg::DIVIDEND_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/ids_ctrl.sv
`include "instance_distribution_selector_core_macros.svh"

module ids_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ids_pkg::ids_stat_t stat,
    output ids_pkg::ids_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.opcode)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.cap_load   = stat.tgt_in_range;
                    cmd.res_status = stat.tgt_in_range ? ids_pkg::STATUS_OK
                                                       : ids_pkg::STATUS_NO_INST;
                    state_next     = ST_DONE;
                end
                else if (stat.n_zero)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ids_pkg::STATUS_NO_INST;
                    state_next     = ST_DONE;
                end
                else
                begin
                    unique case (stat.mode)
                        ids_pkg::MODE_RR:
                        begin
                            cmd.rr_step   = 1'b1;
                            cmd.div_start = 1'b1;
                            state_next    = ST_DIV;
                        end
                        ids_pkg::MODE_LEAST:
                        begin
                            cmd.scan_clear = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        ids_pkg::MODE_RANGE:
                        begin
                            if (stat.char_ok)
                            begin
                                cmd.div_start = 1'b1;
                                cmd.range_sel = 1'b1;
                                state_next    = ST_DIV;
                            end
                            else
                            begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = ids_pkg::STATUS_BAD_CHAR;
                                state_next     = ST_DONE;
                            end
                        end
                        ids_pkg::MODE_NONE:
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ids_pkg::STATUS_NO_ALG;
                            state_next     = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.range_sel = (stat.mode == ids_pkg::MODE_RANGE);
                if (stat.div_done)
                begin
                    cmd.sel_load = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.res_set = 1'b1;
                if (stat.store_ok)
                begin
                    cmd.rd_sel     = 1'b1;
                    cmd.res_status = ids_pkg::STATUS_OK;
                    cmd.res_stored = 1'b1;
                    state_next     = ST_WRITE;
                end
                else
                begin
                    cmd.res_status = ids_pkg::STATUS_REFUSED;
                    state_next     = ST_DONE;
                end
            end
            ST_WRITE:
            begin
                cmd.upd_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `IDS_ASSERT_IMPL(a_div_entry, state_reg == ST_DIV && $past(state_reg) != ST_DIV, $past(state_reg) == ST_DECODE, "divider wait entered from a state other than decode")
    `IDS_ASSERT_NEXT(a_capture_decode, s_tvalid && s_tready, state_reg == ST_DECODE, "accepted item was not decoded")

endmodule

FILE: rtl/ids_dp.sv
`include "instance_distribution_selector_core_macros.svh"

module ids_dp #(
    parameter int MAX_INSTANCES = ids_pkg::MAX_INSTANCES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [ids_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ids_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ids_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ids_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  ids_pkg::ids_cmd_t                  cmd,
    output ids_pkg::ids_stat_t                 stat
);

    localparam int IDX_W = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
    localparam int CNT_W = $clog2(MAX_INSTANCES + 1);

    logic [1:0]                          mode_reg;
    logic [ids_pkg::CFG_DATA_W-1:0]      count_reg;
    logic [CNT_W-1:0]                    n;

    logic                                op_reg;
    logic [7:0]                          ch_reg;
    logic [7:0]                          len_reg;
    logic                                ok_reg;
    logic [3:0]                          tgt_reg;
    logic [31:0]                         capv_reg;

    logic [31:0]                         rr_counter_reg;
    logic [IDX_W-1:0]                    sel_reg;
    logic [CNT_W-1:0]                    scan_idx_reg;
    logic [CNT_W-1:0]                    scan_prev;
    logic [31:0]                         best_free_reg;

    logic [63:0]                         mem [MAX_INSTANCES];
    logic [63:0]                         mem_q_reg;
    logic                                valid_q_reg;
    logic [MAX_INSTANCES-1:0]            valid_reg;
    logic [IDX_W-1:0]                    rd_addr;
    logic [IDX_W-1:0]                    wr_addr;
    logic [IDX_W-1:0]                    tgt_idx;
    logic [63:0]                         wr_data;
    logic                                wr_en;

    logic [31:0]                         cap_q;
    logic [31:0]                         used_q;
    logic [31:0]                         free;
    logic [32:0]                         used_sum;
    logic [31:0]                         used_new;

    logic [7:0]                          ch_off;
    logic [4:0]                          n_ext;
    logic [ids_pkg::DIVIDEND_W-1:0]      div_dvd;
    logic [ids_pkg::DIVISOR_W-1:0]       div_dvs;
    logic                                div_done;
    logic [ids_pkg::DIVIDEND_W-1:0]      div_quo;
    logic [ids_pkg::DIVISOR_W-1:0]       div_rem;
    logic [CNT_W-1:0]                    sel_kr;

    logic [2:0]                          res_status_reg;
    logic                                res_stored_reg;
    logic [3:0]                          chosen;
    logic                                m_tvalid_reg;
    logic [ids_pkg::OUT_TDATA_W-1:0]     m_tdata_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ids_pkg::MODE_RR;
            count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ids_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
                ids_pkg::REG_COUNT: count_reg <= cfg_data;
            endcase
        end
    end

    // Counts above the number of built instances are treated as the maximum.
    assign n = (count_reg > 5'(MAX_INSTANCES)) ? CNT_W'(MAX_INSTANCES) : CNT_W'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= s_tuser;
            ch_reg   <= s_tdata[7:0];
            len_reg  <= s_tdata[15:8];
            ok_reg   <= s_tdata[16];
            tgt_reg  <= s_tdata[20:17];
            capv_reg <= s_tdata[52:21];
        end
    end

    assign ch_off  = ch_reg - ids_pkg::CHAR_A;
    assign n_ext   = 5'(n);
    assign div_dvd = cmd.range_sel ? 32'(ch_off) : rr_counter_reg;
    assign div_dvs = cmd.range_sel ? ids_pkg::PER_TABLE[n_ext] : ids_pkg::DIVISOR_W'(n);

    ids_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign sel_kr = (div_quo >= 32'(n)) ? (n - CNT_W'(1)) : div_quo[CNT_W-1:0];

    // Entries that were never loaded read as zero capacity and zero usage.
    assign tgt_idx  = IDX_W'(tgt_reg);
    assign rd_addr  = cmd.rd_sel ? sel_reg : scan_idx_reg[IDX_W-1:0];
    assign cap_q    = valid_q_reg ? mem_q_reg[63:32] : 32'd0;
    assign used_q   = valid_q_reg ? mem_q_reg[31:0] : 32'd0;
    assign free     = (used_q > cap_q) ? 32'd0 : cap_q - used_q;
    assign used_sum = {1'b0, used_q} + 33'(len_reg);
    assign used_new = (used_sum > {1'b0, cap_q}) ? cap_q : used_sum[31:0];

    assign wr_en   = cmd.cap_load || (cmd.upd_write && valid_q_reg);
    assign wr_addr = cmd.cap_load ? tgt_idx : sel_reg;
    assign wr_data = cmd.cap_load ? {capv_reg, 32'd0} : {cap_q, used_new};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg   <= mem[rd_addr];
        valid_q_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.cap_load)
        begin
            valid_reg[tgt_idx] <= 1'b1;
        end
    end

    assign scan_prev = scan_idx_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rr_counter_reg <= '0;
            sel_reg        <= '0;
            scan_idx_reg   <= '0;
            best_free_reg  <= '0;
        end
        else
        begin
            if (cmd.rr_step)
            begin
                rr_counter_reg <= rr_counter_reg + 32'd1;
            end
            if (cmd.capture || cmd.scan_clear)
            begin
                sel_reg       <= '0;
                scan_idx_reg  <= '0;
                best_free_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                if (scan_idx_reg != '0
                    && (scan_idx_reg == CNT_W'(1) || free > best_free_reg))
                begin
                    sel_reg       <= scan_prev[IDX_W-1:0];
                    best_free_reg <= free;
                end
            end
            else if (cmd.sel_load)
            begin
                sel_reg <= cmd.range_sel ? sel_kr[IDX_W-1:0] : IDX_W'(div_rem);
            end
        end
    end

    assign chosen = op_reg ? tgt_reg : 4'(sel_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_stored_reg <= cmd.res_stored;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {res_status_reg, res_stored_reg, chosen};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.opcode       = op_reg;
    assign stat.tgt_in_range = 32'(tgt_reg) < 32'(MAX_INSTANCES);
    assign stat.n_zero       = (n == '0);
    assign stat.mode         = mode_reg;
    assign stat.char_ok      = (ch_reg >= ids_pkg::CHAR_A) && (ch_reg <= ids_pkg::CHAR_Z);
    assign stat.store_ok     = ok_reg;
    assign stat.div_done     = div_done;
    assign stat.scan_last    = (scan_idx_reg == n);
    assign stat.out_free     = !m_tvalid_reg || m_tready;

    `IDS_ASSERT_IMPL(a_out_slot_free, cmd.out_load, !m_tvalid_reg || m_tready, "result loaded over an item still waiting")
    `IDS_ASSERT_IMPL(a_one_write, cmd.cap_load, !cmd.upd_write, "capacity load and usage update in the same cycle")
    `IDS_ASSERT_NEXT(a_sel_in_range, cmd.sel_load, CNT_W'(sel_reg) < n, "selected instance beyond the active count")
    `IDS_ASSERT_IMPL(a_usage_saturates, cmd.upd_write && valid_q_reg, used_new <= cap_q, "usage update exceeds capacity")

endmodule

FILE: rtl/instance_distribution_selector_core.sv
// Picks the storage instance that takes a key, by round robin, by most free space or by the
// key's first letter, and keeps per-instance capacity and usage for up to MAX_INSTANCES
// instances; one item is handled at a time and each gives one result item. Round robin and
// key range wait on the bit-serial divider that computes the counter modulo the count or the
// letter offset over the letters per instance, one bit per cycle over 32 bits. Most free
// space scans the capacity memory at one entry per cycle. A finished result waits in an
// output register, so the next item is accepted while it is still held. Per-entry valid bits
// clear the capacity and usage memory at reset, so no clearing pass is needed and items are
// accepted straight away.
module instance_distribution_selector_core #(
    parameter int MAX_INSTANCES = ids_pkg::MAX_INSTANCES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // first_char [7:0], key_length [15:8], store_ok [16], target_index [20:17],
    // capacity_value [52:21], zero fill [55:53]
    input  logic [ids_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // chosen_instance [3:0], stored [4], status [7:5]
    output logic [ids_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ids_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ids_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ids_pkg::ids_cmd_t  cmd;
    ids_pkg::ids_stat_t stat;

    ids_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ids_dp #(
        .MAX_INSTANCES (MAX_INSTANCES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
